[rtl/rs485_transaction_controller_defines.svh]
// Assertion helpers for the transaction controller.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef RS485_TRANSACTION_CONTROLLER_DEFINES_SVH
`define RS485_TRANSACTION_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define RTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rtc_pkg.sv]
package rtc_pkg;

	// Buffer sizes of the attached transmit and receive buffers
	localparam int unsigned SEND_BUFFER_BYTES  = 256;
	localparam int unsigned REPLY_BUFFER_BYTES = 256;

	localparam int unsigned LEN_W   = 9;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned RETRY_W = 8;

	// Transmit time estimate: 10 bits per byte at 9600 baud, in ms.
	// len * 10 * 1000 / 9600 = len * 25 / 24 = ((len * 25) >> 3) / 3
	localparam int unsigned TX_EST_MUL  = 25;
	localparam int unsigned TX_EST_SHR  = 3;
	// Divide by 3 via reciprocal: (y * 683) >> 11, exact for y below 1600
	localparam int unsigned DIV3_RECIP  = 683;
	localparam int unsigned DIV3_SHR    = 11;
	localparam int unsigned TX_MARGIN_MS = 50;

	// Event codes
	localparam logic [2:0] OP_START     = 3'd0;
	localparam logic [2:0] OP_TX_DONE   = 3'd1;
	localparam logic [2:0] OP_RX_DONE   = 3'd2;
	localparam logic [2:0] OP_RX_IDLE   = 3'd3;
	localparam logic [2:0] OP_TICK      = 3'd4;
	localparam logic [2:0] OP_ABORT     = 3'd5;
	localparam logic [2:0] OP_CLR_ERR   = 3'd6;
	localparam logic [2:0] OP_FORCE_RST = 3'd7;

	// Link phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_TX      = 3'd1;
	localparam logic [2:0] PH_WAIT    = 3'd2;
	localparam logic [2:0] PH_DONE    = 3'd3;
	localparam logic [2:0] PH_TIMEOUT = 3'd4;
	localparam logic [2:0] PH_ERROR   = 3'd5;

	// Status / fault codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BUSY    = 3'd1;
	localparam logic [2:0] ST_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_HW      = 3'd4;

	// Fault notification codes
	localparam logic [1:0] FEV_NONE    = 2'd0;
	localparam logic [1:0] FEV_TIMEOUT = 2'd1;
	localparam logic [1:0] FEV_HW      = 2'd2;

	// Reset values of the time limits
	localparam logic [TIME_W-1:0] SEND_LIMIT_RST  = 16'd500;
	localparam logic [TIME_W-1:0] REPLY_LIMIT_RST = 16'd1000;

	typedef struct packed {
		logic [2:0]         op;
		logic [LEN_W-1:0]   send_length;
		logic [LEN_W-1:0]   reply_length;
		logic [TIME_W-1:0]  reply_wait_ms;
		logic [LEN_W-1:0]   received_count;
		logic               engine_refused;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [2:0]         link_phase;
		logic               drive_enable;
		logic [LEN_W-1:0]   reply_size;
		logic [2:0]         last_fault;
		logic [RETRY_W-1:0] retries_used;
		logic [CNT_W-1:0]   send_faults;
		logic [CNT_W-1:0]   reply_faults;
		logic [CNT_W-1:0]   timeouts_seen;
		logic [1:0]         fault_event;
		logic               reply_event;
		logic               send_event;
	} rsp_t;

endpackage

[rtl/rs485_transaction_controller.sv]
// Channel  | Direction | Handshake          | Payload
// cmd      | in        | cmd_valid/stall    | rtc_pkg::cmd_t, one event
// rsp      | out       | rsp_valid/stall    | rtc_pkg::rsp_t, one result per event
// cfg      | in        | cfg_valid/ready    | retry_limit, 8 bits
//
// One event per cycle while rsp is not stalled; each result reaches rsp through
// the input register, then the result register.
// All state updates in the single pass between the two registers.
// arst_n clears all state but the rsp payload register; retry_limit resets
// to 0, the time limits to 500/1000. A stalled rsp holds the result register;
// the input register then holds too and cmd_stall rises until the result is taken.
`include "rs485_transaction_controller_defines.svh"

module rs485_transaction_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  rtc_pkg::cmd_t               cmd_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output rtc_pkg::rsp_t               rsp_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rtc_pkg::RETRY_W-1:0] cfg_data
);
	import rtc_pkg::*;

	// Input stage
	cmd_t cmd_s1;
	logic valid_s1;

	// Result register
	rsp_t rsp_q;
	logic rsp_valid_q;

	// Controller state
	logic [RETRY_W-1:0] retry_limit_q;
	logic [2:0]         phase_q;
	logic               enable_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [TIME_W-1:0]  send_limit_q;
	logic [TIME_W-1:0]  reply_limit_q;
	logic [LEN_W-1:0]   expected_q;
	logic [LEN_W-1:0]   send_size_q;
	logic [LEN_W-1:0]   got_size_q;
	logic [RETRY_W-1:0] retry_q;
	logic [2:0]         fault_q;
	logic [CNT_W-1:0]   send_cnt_q;
	logic [CNT_W-1:0]   reply_cnt_q;
	logic [CNT_W-1:0]   tmo_cnt_q;

	// Next values
	logic [2:0]         phase_d;
	logic               enable_d;
	logic [TIME_W-1:0]  elapsed_d;
	logic [TIME_W-1:0]  send_limit_d;
	logic [TIME_W-1:0]  reply_limit_d;
	logic [LEN_W-1:0]   expected_d;
	logic [LEN_W-1:0]   send_size_d;
	logic [LEN_W-1:0]   got_size_d;
	logic [RETRY_W-1:0] retry_d;
	logic [2:0]         fault_d;
	logic [CNT_W-1:0]   send_cnt_d;
	logic [CNT_W-1:0]   reply_cnt_d;
	logic [CNT_W-1:0]   tmo_cnt_d;
	logic [2:0]         status_d;
	logic [1:0]         fev_d;
	logic               rev_d;
	logic               sev_d;

	// Helper values
	logic               advance;
	logic               len_bad;
	logic [13:0]        est_x25;
	logic [10:0]        est_q8;
	logic [21:0]        est_prod;
	logic [10:0]        est_ms;
	logic [TIME_W-1:0]  send_limit_new;
	logic [TIME_W-1:0]  elapsed_inc;
	logic [LEN_W-1:0]   rx_clamped;
	logic               retry_left;

	// Handshakes
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = !advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else if (advance && cmd_valid) begin
			cmd_s1 <= cmd_data;
		end
	end

	// Length check and transmit time estimate
	assign len_bad = (cmd_s1.send_length == '0)
		|| ({5'd0, cmd_s1.send_length} > 14'(SEND_BUFFER_BYTES))
		|| ({5'd0, cmd_s1.reply_length} > 14'(REPLY_BUFFER_BYTES));
	assign est_x25  = 14'(cmd_s1.send_length) * 14'(TX_EST_MUL);
	assign est_q8   = 11'(est_x25 >> TX_EST_SHR);
	assign est_prod = 22'(est_q8) * 22'(DIV3_RECIP);
	assign est_ms   = 11'(est_prod >> DIV3_SHR);
	assign send_limit_new = TIME_W'({est_ms, 1'b0}) + TIME_W'(TX_MARGIN_MS);

	// Saturating elapsed time after a tick
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	// Idle-line byte count clamped to the buffer
	assign rx_clamped = ({5'd0, cmd_s1.received_count} > 14'(REPLY_BUFFER_BYTES))
		? LEN_W'(REPLY_BUFFER_BYTES) : cmd_s1.received_count;

	assign retry_left = retry_q < retry_limit_q;

	// Event processing
	always_comb begin
		phase_d       = phase_q;
		enable_d      = enable_q;
		elapsed_d     = elapsed_q;
		send_limit_d  = send_limit_q;
		reply_limit_d = reply_limit_q;
		expected_d    = expected_q;
		send_size_d   = send_size_q;
		got_size_d    = got_size_q;
		retry_d       = retry_q;
		fault_d       = fault_q;
		send_cnt_d    = send_cnt_q;
		reply_cnt_d   = reply_cnt_q;
		tmo_cnt_d     = tmo_cnt_q;
		status_d      = ST_OK;
		fev_d         = FEV_NONE;
		rev_d         = 1'b0;
		sev_d         = 1'b0;

		unique case (cmd_s1.op)
			OP_START: begin
				if (len_bad) begin
					fault_d  = ST_INVALID;
					status_d = ST_INVALID;
				end else if (phase_q != PH_IDLE) begin
					fault_d  = ST_BUSY;
					status_d = ST_BUSY;
				end else begin
					send_size_d   = cmd_s1.send_length;
					expected_d    = cmd_s1.reply_length;
					got_size_d    = '0;
					reply_limit_d = cmd_s1.reply_wait_ms;
					send_limit_d  = send_limit_new;
					elapsed_d     = '0;
					if (cmd_s1.engine_refused) begin
						enable_d   = 1'b0;
						phase_d    = PH_IDLE;
						fault_d    = ST_HW;
						send_cnt_d = send_cnt_q + 1'b1;
						status_d   = ST_HW;
					end else begin
						enable_d = 1'b1;
						phase_d  = PH_TX;
						fault_d  = ST_OK;
					end
				end
			end
			OP_TX_DONE: begin
				if (phase_q == PH_TX) begin
					enable_d = 1'b0;
					sev_d    = 1'b1;
					if (expected_q != '0) begin
						if (cmd_s1.engine_refused) begin
							phase_d     = PH_ERROR;
							fault_d     = ST_HW;
							reply_cnt_d = reply_cnt_q + 1'b1;
							fev_d       = FEV_HW;
						end else begin
							phase_d   = PH_WAIT;
							elapsed_d = '0;
							fault_d   = ST_OK;
						end
					end else begin
						phase_d = PH_IDLE;
						retry_d = '0;
					end
				end
			end
			OP_RX_DONE, OP_RX_IDLE: begin
				if (phase_q == PH_WAIT) begin
					got_size_d = (cmd_s1.op == OP_RX_DONE) ? expected_q : rx_clamped;
					phase_d    = PH_DONE;
					fault_d    = ST_OK;
					retry_d    = '0;
					rev_d      = 1'b1;
				end
			end
			OP_TICK: begin
				elapsed_d = elapsed_inc;
				// Timeout with retry: back to idle while retries remain, else to PH_ERROR or PH_TIMEOUT
				if (phase_q == PH_TX) begin
					if (elapsed_inc >= send_limit_q) begin
						enable_d   = 1'b0;
						send_cnt_d = send_cnt_q + 1'b1;
						fault_d    = ST_TIMEOUT;
						tmo_cnt_d  = tmo_cnt_q + 1'b1;
						fev_d      = FEV_TIMEOUT;
						if (retry_left) begin
							retry_d = retry_q + 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_ERROR;
						end
					end
				end else if (phase_q == PH_WAIT) begin
					if (elapsed_inc >= reply_limit_q) begin
						reply_cnt_d = reply_cnt_q + 1'b1;
						fault_d     = ST_TIMEOUT;
						tmo_cnt_d   = tmo_cnt_q + 1'b1;
						fev_d       = FEV_TIMEOUT;
						if (retry_left) begin
							retry_d = retry_q + 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_TIMEOUT;
						end
					end
				end else if (phase_q == PH_TIMEOUT) begin
					phase_d = PH_IDLE;
					retry_d = '0;
				end
			end
			OP_ABORT: begin
				enable_d    = 1'b0;
				phase_d     = PH_IDLE;
				got_size_d  = '0;
				send_size_d = '0;
			end
			OP_CLR_ERR: begin
				fault_d = ST_OK;
				retry_d = '0;
				if (phase_q == PH_ERROR || phase_q == PH_TIMEOUT) begin
					phase_d = PH_IDLE;
				end
			end
			OP_FORCE_RST: begin
				enable_d    = 1'b0;
				send_size_d = '0;
				got_size_d  = '0;
				phase_d     = PH_IDLE;
				retry_d     = '0;
				fault_d     = ST_OK;
			end
		endcase
	end

	// State update, one event per accepted step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= '0;
			phase_q       <= PH_IDLE;
			enable_q      <= 1'b0;
			elapsed_q     <= '0;
			send_limit_q  <= SEND_LIMIT_RST;
			reply_limit_q <= REPLY_LIMIT_RST;
			expected_q    <= '0;
			send_size_q   <= '0;
			got_size_q    <= '0;
			retry_q       <= '0;
			fault_q       <= ST_OK;
			send_cnt_q    <= '0;
			reply_cnt_q   <= '0;
			tmo_cnt_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				retry_limit_q <= cfg_data;
			end
			if (valid_s1 && advance) begin
				phase_q       <= phase_d;
				enable_q      <= enable_d;
				elapsed_q     <= elapsed_d;
				send_limit_q  <= send_limit_d;
				reply_limit_q <= reply_limit_d;
				expected_q    <= expected_d;
				send_size_q   <= send_size_d;
				got_size_q    <= got_size_d;
				retry_q       <= retry_d;
				fault_q       <= fault_d;
				send_cnt_q    <= send_cnt_d;
				reply_cnt_q   <= reply_cnt_d;
				tmo_cnt_q     <= tmo_cnt_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.status        <= status_d;
			rsp_q.link_phase    <= phase_d;
			rsp_q.drive_enable  <= enable_d;
			rsp_q.reply_size    <= got_size_d;
			rsp_q.last_fault    <= fault_d;
			rsp_q.retries_used  <= retry_d;
			rsp_q.send_faults   <= send_cnt_d;
			rsp_q.reply_faults  <= reply_cnt_d;
			rsp_q.timeouts_seen <= tmo_cnt_d;
			rsp_q.fault_event   <= fev_d;
			rsp_q.reply_event   <= rev_d;
			rsp_q.send_event    <= sev_d;
		end
	end

	// Driver is only enabled while transmitting
	`RTC_ASSERT_NOW(a_enable_in_tx, enable_q, phase_q == PH_TX, "driver enabled outside transmit")
	// A held request is not dropped while the result side is stalled
	`RTC_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1, "held request lost")
	// A completed reply always reports the reply-done phase
	`RTC_ASSERT_NOW(a_reply_phase, rsp_valid_q && rsp_q.reply_event,
		rsp_q.link_phase == PH_DONE, "reply event outside reply-done phase")

endmodule
